>>> hdl/swse_pkg.sv
package swse_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 16;
    localparam int SETTLE_W   = 5;
    localparam int MINP_W     = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINP   = 4'd1;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 5'd10;
    localparam logic [MINP_W-1:0]   MINP_RESET   = 6'd5;
    localparam logic [TIME_W-1:0]   TIME_MAX     = 16'hFFFF;

    // sized for the largest supported window (256 entries)
    localparam int N_W        = 9;
    localparam int SLOT_MAX_W = 8;

    localparam int SY_W    = 24;
    localparam int SUY_W   = 34;
    localparam int SU_W    = 16;
    localparam int SUU_W   = 24;
    localparam int NUM_W   = 45;
    localparam int DEN_W   = 32;
    localparam int SX_W    = 26;
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 27;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DVD_W   = 60;
    localparam int FRAC_SH = 12;
    localparam int SLOPE_W = 32;
    localparam int ICPT_W  = 48;

    typedef struct packed {
        logic                       heat_flag;
        logic signed [SAMPLE_W-1:0] sample;
    } in_t;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  intercept;
        logic                      fit_valid;
    } out_t;

    typedef struct packed {
        logic                  fit;
        logic [N_W-1:0]        n;
        logic [SLOT_MAX_W-1:0] last_slot;
        logic [TIME_W-1:0]     ti;
    } job_t;

endpackage

>>> hdl/sliding_window_slope_estimator_core.sv
// channel  | ports                                  | carries
// ---------+----------------------------------------+---------------------------------
// input    | s_valid, s_ready, s_data               | heat_flag, sample (Q12.4)
// result   | m_valid, m_ready, m_data               | slope, intercept, fit_valid
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | settle_count (0), min_points (1)
//
// the front takes a transaction, writes the ring and queues a job in the same cycle
// a fitted job walks the ring, then takes six multiply steps, a serial division for the slope
// (skipped when the denominator is zero) and one for the intercept; an unfitted job goes straight to output
// s_ready is low while the back end walks the ring or a job is still queued
// a waiting result blocks the front only once a job is queued behind it; reset is synchronous, active low
module sliding_window_slope_estimator_core #(
    parameter int WINDOW_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  swse_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output swse_pkg::out_t                  m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [swse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swse_pkg::CFG_DATA_W-1:0] cfg_data
);

    import swse_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_WIDTH);

    job_t              push_job;
    job_t              pop_job;
    logic              job_push;
    logic              job_pop;
    logic              q_empty;
    logic              q_full;
    logic              walking;
    logic              hold;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic [SAMPLE_W-1:0] rd_data;

    // the ring may only change once the queued window has been summed
    assign hold = ~q_empty | walking;

    swse_front #(.WINDOW_WIDTH(WINDOW_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .hold      (hold),
        .job_push  (job_push),
        .job       (push_job),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    swse_ram #(.DW(SAMPLE_W), .DEPTH(WINDOW_WIDTH)) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    swse_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (push_job),
        .pop       (job_pop),
        .pop_data  (pop_job),
        .empty     (q_empty),
        .full      (q_full)
    );

    swse_back #(.WINDOW_WIDTH(WINDOW_WIDTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (~q_empty),
        .job_pop   (job_pop),
        .job       (pop_job),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .walking   (walking),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_no_queue_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(job_push && q_full))
        else $error("job queue overflow");

    a_ring_write_not_during_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en))
        else $error("ring written while window is read");

    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.fit_valid) |-> (m_data.slope == '0 && m_data.intercept == '0))
        else $error("unfitted result not zero");

    a_one_result_per_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> !m_valid)
        else $error("result repeated");

endmodule

>>> hdl/swse_ram.sv
module swse_ram #(
    parameter int DW    = 16,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/swse_front.sv
module swse_front #(
    parameter int WINDOW_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  swse_pkg::in_t                       s_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swse_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                hold,
    output logic                                job_push,
    output swse_pkg::job_t                      job,
    output logic                                wr_en,
    output logic [$clog2(WINDOW_WIDTH)-1:0]     wr_addr,
    output logic [swse_pkg::SAMPLE_W-1:0]       wr_data
);

    import swse_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_WIDTH);
    localparam int CNT_W  = $clog2(WINDOW_WIDTH + 2);
    localparam int CMP_W  = (CNT_W > MINP_W) ? CNT_W : MINP_W;

    logic [SETTLE_W-1:0] settle_reg;
    logic [MINP_W-1:0]   minp_reg;
    logic [TIME_W-1:0]   ti_reg,     ti_next;
    logic [SLOT_W-1:0]   slot_reg,   slot_next;
    logic [CNT_W-1:0]    stable_reg, stable_next;

    logic [TIME_W-1:0] ti_cur;
    logic [SLOT_W-1:0] slot_cur;
    logic [CNT_W-1:0]  stable_base;
    logic [CNT_W-1:0]  n_cnt;
    logic              accept;

    assign s_ready   = ~hold;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid & s_ready;

    always_comb begin
        ti_cur      = s_data.heat_flag ? '0 : ti_reg;
        slot_cur    = s_data.heat_flag ? '0 : slot_reg;
        // still settling: drop what was counted so far
        stable_base = (ti_cur <= TIME_W'(settle_reg)) ? '0 : stable_reg;
        stable_next = (stable_base < CNT_W'(WINDOW_WIDTH + 1)) ? stable_base + 1'b1
                                                               : stable_base;
        slot_next   = (slot_cur == SLOT_W'(WINDOW_WIDTH - 1)) ? '0 : slot_cur + 1'b1;
        ti_next     = (ti_cur == TIME_MAX) ? ti_cur : ti_cur + 1'b1;
        n_cnt       = (stable_next < CNT_W'(WINDOW_WIDTH)) ? stable_next
                                                           : CNT_W'(WINDOW_WIDTH);
    end

    assign job_push      = accept;
    assign job.fit       = CMP_W'(stable_next) > CMP_W'(minp_reg);
    assign job.n         = N_W'(n_cnt);
    assign job.last_slot = SLOT_MAX_W'(slot_cur);
    assign job.ti        = ti_next;

    assign wr_en   = accept;
    assign wr_addr = slot_cur;
    assign wr_data = s_data.sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_RESET;
            minp_reg   <= MINP_RESET;
            ti_reg     <= '0;
            slot_reg   <= '0;
            stable_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SETTLE) begin
                    settle_reg <= cfg_data[SETTLE_W-1:0];
                end
                if (cfg_index == REG_MINP) begin
                    minp_reg <= cfg_data[MINP_W-1:0];
                end
            end
            if (accept) begin
                ti_reg     <= ti_next;
                slot_reg   <= slot_next;
                stable_reg <= stable_next;
            end
        end
    end

endmodule

>>> hdl/swse_fifo.sv
module swse_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  swse_pkg::job_t push_data,
    input  logic           pop,
    output swse_pkg::job_t pop_data,
    output logic           empty,
    output logic           full
);

    import swse_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if ((push && !full) && !(pop && !empty)) begin
                count_reg <= count_reg + 1'b1;
            end else if (!(push && !full) && (pop && !empty)) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/swse_back.sv
module swse_back #(
    parameter int WINDOW_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            job_valid,
    output logic                            job_pop,
    input  swse_pkg::job_t                  job,
    output logic                            rd_en,
    output logic [$clog2(WINDOW_WIDTH)-1:0] rd_addr,
    input  logic [swse_pkg::SAMPLE_W-1:0]   rd_data,
    output logic                            walking,
    output logic                            m_valid,
    input  logic                            m_ready,
    output swse_pkg::out_t                  m_data
);

    import swse_pkg::*;

    localparam int SLOT_W    = $clog2(WINDOW_WIDTH);
    localparam int U_W       = N_W - 1;
    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam logic [DVD_W-1:0] SLOPE_LIM = DVD_W'(64'h0000_0000_8000_0000);
    localparam logic [DVD_W-1:0] ICPT_LIM  = DVD_W'(64'h0000_8000_0000_0000);

    typedef enum logic [3:0] {
        S_IDLE, S_WALK, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
        S_DS, S_SL, S_M7, S_DIL, S_DI, S_IC, S_OUT
    } state_t;

    state_t state_reg;
    job_t   job_reg;

    logic [SLOT_W-1:0] addr_reg;
    logic [N_W-1:0]    u_reg;
    logic [N_W-1:0]    left_reg;
    logic [U_W-1:0]    u_d_reg;
    logic              rd_vld_reg;

    logic signed [SY_W-1:0]  sy_reg;
    logic signed [SUY_W-1:0] suy_reg;
    logic [SU_W-1:0]         su_reg;
    logic [SUU_W-1:0]        suu_reg;

    logic signed [PROD_W-1:0]  mul_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]          den_reg;
    logic signed [SX_W-1:0]    sx_reg;
    logic signed [SLOPE_W-1:0] slope_reg;
    logic signed [ICPT_W-1:0]  icpt_reg;

    logic [DVD_W-1:0]     dvd_reg;
    logic [DEN_W-1:0]     dvs_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [TIME_W+1:0]   ti_minus_n;
    logic signed [SAMPLE_W-1:0] v;
    logic signed [SAMPLE_W+U_W:0] uv;
    logic [2*U_W-1:0]           uu;
    logic [NUM_W-1:0]           num_mag;
    logic signed [DVD_W:0]      ic_num;
    logic [DVD_W-1:0]           ic_mag;
    logic [DEN_W:0]             rem_sh;
    logic [DEN_W:0]             rem_dif;
    logic                       q_bit;

    assign job_pop = (state_reg == S_IDLE) && job_valid;
    assign rd_en   = (state_reg == S_WALK) && (left_reg != '0);
    assign rd_addr = addr_reg;
    assign walking = (state_reg == S_WALK);

    assign m_valid          = (state_reg == S_OUT);
    assign m_data.slope     = slope_reg;
    assign m_data.intercept = icpt_reg;
    assign m_data.fit_valid = job_reg.fit;

    always_comb begin
        v  = $signed(rd_data);
        uv = $signed({1'b0, u_d_reg}) * v;
        uu = u_d_reg * u_d_reg;
        ti_minus_n = $signed({2'b00, job_reg.ti})
                   - $signed({{(TIME_W + 2 - N_W){1'b0}}, job_reg.n});
        num_mag = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        ic_num  = ((DVD_W+1)'(sy_reg) <<< FRAC_SH) - (DVD_W+1)'(mul_reg);
        ic_mag  = ic_num[DVD_W] ? DVD_W'(-ic_num) : DVD_W'(ic_num);
        rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
        rem_dif = rem_sh - {1'b0, dvs_reg};
        q_bit   = (rem_sh >= {1'b0, dvs_reg});
    end

    // one shared multiplier, operands picked by the sequencer step
    always_comb begin
        case (state_reg)
            S_M0: begin
                mul_a = MUL_A_W'(suy_reg);
                mul_b = MUL_B_W'(job_reg.n);
            end
            S_M1: begin
                mul_a = MUL_A_W'(sy_reg);
                mul_b = MUL_B_W'(su_reg);
            end
            S_M2: begin
                mul_a = MUL_A_W'(suu_reg);
                mul_b = MUL_B_W'(job_reg.n);
            end
            S_M3: begin
                mul_a = MUL_A_W'(su_reg);
                mul_b = MUL_B_W'(su_reg);
            end
            S_M4: begin
                mul_a = MUL_A_W'(ti_minus_n);
                mul_b = MUL_B_W'(job_reg.n);
            end
            S_M7: begin
                mul_a = MUL_A_W'(slope_reg);
                mul_b = MUL_B_W'(sx_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= 1'b0;
            mul_reg    <= prod;
            case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        job_reg  <= job;
                        addr_reg <= job.last_slot[SLOT_W-1:0];
                        u_reg    <= job.n - 1'b1;
                        left_reg <= job.n;
                        sy_reg   <= '0;
                        suy_reg  <= '0;
                        su_reg   <= '0;
                        suu_reg  <= '0;
                        if (job.fit) begin
                            state_reg <= S_WALK;
                        end else begin
                            slope_reg <= '0;
                            icpt_reg  <= '0;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_WALK: begin
                    // newest sample first, u counts down to the oldest
                    if (left_reg != '0) begin
                        rd_vld_reg <= 1'b1;
                        u_d_reg    <= u_reg[U_W-1:0];
                        u_reg      <= u_reg - 1'b1;
                        left_reg   <= left_reg - 1'b1;
                        addr_reg   <= (addr_reg == '0) ? SLOT_W'(WINDOW_WIDTH - 1)
                                                       : addr_reg - 1'b1;
                    end
                    if (rd_vld_reg) begin
                        sy_reg  <= sy_reg + SY_W'(v);
                        suy_reg <= suy_reg + SUY_W'(uv);
                        su_reg  <= su_reg + SU_W'(u_d_reg);
                        suu_reg <= suu_reg + SUU_W'(uu);
                    end
                    if ((left_reg == '0) && !rd_vld_reg) begin
                        state_reg <= S_M0;
                    end
                end
                S_M0: state_reg <= S_M1;
                S_M1: begin
                    num_reg   <= NUM_W'(mul_reg);
                    state_reg <= S_M2;
                end
                S_M2: begin
                    num_reg   <= num_reg - NUM_W'(mul_reg);
                    state_reg <= S_M3;
                end
                S_M3: begin
                    den_reg   <= DEN_W'(mul_reg);
                    state_reg <= S_M4;
                end
                S_M4: begin
                    den_reg   <= den_reg - DEN_W'(mul_reg);
                    state_reg <= S_M5;
                end
                S_M5: begin
                    sx_reg <= SX_W'(mul_reg) + SX_W'(su_reg);
                    if (den_reg == '0) begin
                        // single point: flat line through the sample
                        slope_reg <= '0;
                        state_reg <= S_M7;
                    end else begin
                        dvd_reg   <= (DVD_W'(num_mag) << FRAC_SH) + DVD_W'(den_reg >> 1);
                        dvs_reg   <= den_reg;
                        neg_reg   <= num_reg[NUM_W-1];
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DS;
                    end
                end
                S_DS, S_DI: begin
                    rem_reg <= q_bit ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                    dvd_reg <= {dvd_reg[DVD_W-2:0], q_bit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_CNT_W'(DVD_W - 1)) begin
                        state_reg <= (state_reg == S_DS) ? S_SL : S_IC;
                    end
                end
                S_SL: begin
                    if (neg_reg) begin
                        slope_reg <= (dvd_reg > SLOPE_LIM) ? {1'b1, {(SLOPE_W-1){1'b0}}}
                                                           : -SLOPE_W'(dvd_reg);
                    end else begin
                        slope_reg <= (dvd_reg > SLOPE_LIM - 1'b1)
                                   ? {1'b0, {(SLOPE_W-1){1'b1}}} : SLOPE_W'(dvd_reg);
                    end
                    state_reg <= S_M7;
                end
                S_M7: state_reg <= S_DIL;
                S_DIL: begin
                    dvd_reg   <= ic_mag + DVD_W'(job_reg.n >> 1);
                    dvs_reg   <= DEN_W'(job_reg.n);
                    neg_reg   <= ic_num[DVD_W];
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DI;
                end
                S_IC: begin
                    if (neg_reg) begin
                        icpt_reg <= (dvd_reg > ICPT_LIM) ? {1'b1, {(ICPT_W-1){1'b0}}}
                                                         : -ICPT_W'(dvd_reg);
                    end else begin
                        icpt_reg <= (dvd_reg > ICPT_LIM - 1'b1)
                                  ? {1'b0, {(ICPT_W-1){1'b1}}} : ICPT_W'(dvd_reg);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
